// ----- sv/lfu_cache_assert.svh -----
// assertion macros shared by the lfu cache checker
`ifndef LFU_CACHE_ASSERT_SVH
`define LFU_CACHE_ASSERT_SVH

// same-cycle implication, disabled while reset is asserted
`define LFU_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("lfu_cache: same-cycle check failed");

// next-cycle implication, disabled while reset is asserted
`define LFU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("lfu_cache: next-cycle check failed");

`endif

// ----- sv/lfu_pkg.sv -----
// constants shared by the lfu cache and its checker
`default_nettype none

package lfu_pkg;

	// number of entries held
	localparam int CAPACITY = 16;

	// field widths; the index, occupancy and limit widths are derived
	localparam int IDX_W  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int OCC_W  = $clog2(CAPACITY + 1);
	localparam int CAP_W  = 5;
	localparam int LIM_W  = (OCC_W > CAP_W) ? OCC_W : CAP_W;
	localparam int KEY_W  = 32;
	localparam int DATA_W = 32;
	localparam int CNT_W  = 32;

	// capacity register reset value
	localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

	// value returned by a get that misses
	localparam logic [DATA_W-1:0] MISS_VALUE = {DATA_W{1'b1}};

	// operation codes
	localparam logic OP_GET = 1'b0;
	localparam logic OP_PUT = 1'b1;

endpackage

`default_nettype wire

// ----- sv/lfu_cache.sv -----
// lfu_cache: least-frequently-used key/value cache with least-recent tie-break
//
// channels: cfg (cfg_valid/cfg_ready/cfg_data) writes the capacity register;
// cfg_ready is always high, and writes are meant to land while no item is in
// flight. in (in_valid/in_ready) carries op, key and value; out
// (out_valid/out_ready) carries hit and read_value, one result per get and
// none per put.
// each item passes through a capture step, a scan over the entries, where a
// single key compare and a single count/rank compare look for the match, the
// eviction victim and the first free slot, one entry at a time, and a
// write-back step. in_ready is high only between items.
// a get's result is registered at write-back, which a stall can hold back.
// results sit in an output register: the next item is taken while a result
// waits, and a get that finishes while the receiver still stalls holds in
// write-back until the register frees up. a put never waits on the receiver.
// reset clears all valid bits, the occupancy, the pending result and sets
// capacity to 16; no clearing pass is needed.
`default_nettype none

module lfu_cache (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_valid,
	output logic                                   cfg_ready,
	input  wire logic [lfu_pkg::CAP_W-1:0]         cfg_data,
	input  wire logic                              in_valid,
	output logic                                   in_ready,
	input  wire logic                              op,
	input  wire logic signed [lfu_pkg::KEY_W-1:0]  key,
	input  wire logic signed [lfu_pkg::DATA_W-1:0] value,
	output logic                                   out_valid,
	input  wire logic                              out_ready,
	output logic                                   hit,
	output logic signed [lfu_pkg::DATA_W-1:0]      read_value
);

	localparam int N      = lfu_pkg::CAPACITY;
	localparam int IdxW   = lfu_pkg::IDX_W;
	localparam int OccW   = lfu_pkg::OCC_W;
	localparam int LimW   = lfu_pkg::LIM_W;
	localparam int KeyW   = lfu_pkg::KEY_W;
	localparam int DataW  = lfu_pkg::DATA_W;
	localparam int CntW   = lfu_pkg::CNT_W;

	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_SCAN   = 2'd1;
	localparam logic [1:0] ST_UPDATE = 2'd2;

	localparam logic [IdxW-1:0] LAST_IDX = IdxW'(N - 1);

	// control state
	logic [1:0]                   state_q;
	logic [IdxW-1:0]              idx_q;
	logic [N-1:0]                 valid_q;
	logic [OccW-1:0]              occ_q;
	logic [lfu_pkg::CAP_W-1:0]    capacity_q;
	logic                         out_valid_q;
	logic                         hit_found_q;
	logic                         vic_found_q;
	logic                         ff_found_q;

	// captured item and scan results
	logic                         op_q;
	logic [KeyW-1:0]              key_q;
	logic [DataW-1:0]             val_q;
	logic [IdxW-1:0]              hit_idx_q;
	logic [DataW-1:0]             hit_val_q;
	logic [CntW-1:0]              hit_cnt_q;
	logic [IdxW-1:0]              hit_rank_q;
	logic [IdxW-1:0]              vic_idx_q;
	logic [CntW-1:0]              vic_cnt_q;
	logic [IdxW-1:0]              vic_rank_q;
	logic [IdxW-1:0]              ff_idx_q;

	// entry store
	logic [KeyW-1:0]              ent_key_q   [N];
	logic [DataW-1:0]             ent_val_q   [N];
	logic [CntW-1:0]              ent_cnt_q   [N];
	logic [IdxW-1:0]              ent_rank_q  [N];

	// result register
	logic                         hit_q;
	logic [DataW-1:0]             rdata_q;

	// combinational
	logic [LimW-1:0]              lim;
	logic                         lim_zero;
	logic                         scan_valid;
	logic [CntW-1:0]              scan_cnt;
	logic [IdxW-1:0]              scan_rank;
	logic                         scan_match;
	logic                         scan_better;
	logic                         go;
	logic                         upd_en;
	logic                         touch_en;
	logic                         ins_path;
	logic                         evict;
	logic                         slot_ok;
	logic [IdxW-1:0]              slot;
	logic                         do_insert;
	logic [CntW-1:0]              hit_cnt_inc;

	assign cfg_ready  = 1'b1;
	assign in_ready   = (state_q == ST_IDLE);
	assign out_valid  = out_valid_q;
	assign hit        = hit_q;
	assign read_value = rdata_q;

	// effective entry limit
	assign lim      = (LimW'(capacity_q) > LimW'(N)) ? LimW'(N) : LimW'(capacity_q);
	assign lim_zero = (lim == '0);

	// shared compare unit over the entry under scan
	assign scan_valid  = valid_q[idx_q];
	assign scan_cnt    = ent_cnt_q[idx_q];
	assign scan_rank   = ent_rank_q[idx_q];
	assign scan_match  = scan_valid && (ent_key_q[idx_q] == key_q);
	assign scan_better = scan_valid && (!vic_found_q || (scan_cnt < vic_cnt_q) ||
		((scan_cnt == vic_cnt_q) && (scan_rank > vic_rank_q)));

	// write-back decisions
	assign go          = (op_q == lfu_pkg::OP_PUT) || !out_valid_q || out_ready;
	assign upd_en      = (state_q == ST_UPDATE) && go;
	assign touch_en    = hit_found_q && ((op_q == lfu_pkg::OP_GET) || !lim_zero);
	assign ins_path    = (op_q == lfu_pkg::OP_PUT) && !lim_zero && !hit_found_q;
	assign evict       = ins_path && (LimW'(occ_q) >= lim) && vic_found_q;
	assign slot_ok     = evict || ff_found_q;
	assign slot        = (evict && !(ff_found_q && (ff_idx_q < vic_idx_q))) ? vic_idx_q
		: ff_idx_q;
	assign do_insert   = ins_path && slot_ok;
	assign hit_cnt_inc = (hit_cnt_q == {CntW{1'b1}}) ? hit_cnt_q : (hit_cnt_q + 1'b1);

	// sequencer, valid bits, occupancy and handshake state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			idx_q       <= '0;
			valid_q     <= '0;
			occ_q       <= '0;
			capacity_q  <= lfu_pkg::CAP_RESET;
			out_valid_q <= 1'b0;
			hit_found_q <= 1'b0;
			vic_found_q <= 1'b0;
			ff_found_q  <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				capacity_q <= cfg_data;
			end
			// result register: a finished get loads it, the receiver empties it
			if (upd_en && (op_q == lfu_pkg::OP_GET)) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q     <= ST_SCAN;
						idx_q       <= '0;
						hit_found_q <= 1'b0;
						vic_found_q <= 1'b0;
						ff_found_q  <= 1'b0;
					end
				end
				ST_SCAN: begin
					if (scan_match && !hit_found_q) begin
						hit_found_q <= 1'b1;
					end
					if (scan_better) begin
						vic_found_q <= 1'b1;
					end
					if (!scan_valid) begin
						ff_found_q <= 1'b1;
					end
					if (idx_q == LAST_IDX) begin
						state_q <= ST_UPDATE;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				ST_UPDATE: begin
					if (go) begin
						state_q <= ST_IDLE;
						// the victim's slot is reused unless a free slot lies below it
						if (evict && (slot != vic_idx_q)) begin
							valid_q[vic_idx_q] <= 1'b0;
						end
						if (do_insert) begin
							valid_q[slot] <= 1'b1;
						end
						occ_q <= occ_q - OccW'(evict) + OccW'(do_insert);
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// item capture, scan captures, entry store and result payload
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			op_q  <= op;
			key_q <= key;
			val_q <= value;
		end
		if (state_q == ST_SCAN) begin
			if (scan_match && !hit_found_q) begin
				hit_idx_q  <= idx_q;
				hit_val_q  <= ent_val_q[idx_q];
				hit_cnt_q  <= scan_cnt;
				hit_rank_q <= scan_rank;
			end
			if (scan_better) begin
				vic_idx_q  <= idx_q;
				vic_cnt_q  <= scan_cnt;
				vic_rank_q <= scan_rank;
			end
			if (!scan_valid && !ff_found_q) begin
				ff_idx_q <= idx_q;
			end
		end
		if (upd_en) begin
			// result of a get
			if (op_q == lfu_pkg::OP_GET) begin
				hit_q   <= hit_found_q;
				rdata_q <= hit_found_q ? hit_val_q : lfu_pkg::MISS_VALUE;
			end
			// per-entry rank lanes
			for (int j = 0; j < N; j++) begin
				if (touch_en) begin
					if (valid_q[j] && (ent_rank_q[j] < hit_rank_q)) begin
						ent_rank_q[j] <= ent_rank_q[j] + 1'b1;
					end
				end else if (do_insert) begin
					if (valid_q[j] && !(evict && (IdxW'(j) == vic_idx_q))) begin
						ent_rank_q[j] <= ent_rank_q[j] + 1'b1 -
							IdxW'(evict && (ent_rank_q[j] > vic_rank_q));
					end
				end
			end
			// touched entry
			if (touch_en) begin
				ent_rank_q[hit_idx_q] <= '0;
				ent_cnt_q[hit_idx_q]  <= hit_cnt_inc;
				if (op_q == lfu_pkg::OP_PUT) begin
					ent_val_q[hit_idx_q] <= val_q;
				end
			end
			// inserted entry
			if (do_insert) begin
				ent_key_q[slot]  <= key_q;
				ent_val_q[slot]  <= val_q;
				ent_cnt_q[slot]  <= CntW'(1);
				ent_rank_q[slot] <= '0;
			end
		end
	end

endmodule

`default_nettype wire

// ----- sv/lfu_chk.sv -----
// port-level checker for the lfu cache, bound to lfu_cache
`default_nettype none

`include "lfu_cache_assert.svh"

module lfu_chk (
	input wire logic                              clk,
	input wire logic                              arst_n,
	input wire logic                              in_valid,
	input wire logic                              in_ready,
	input wire logic                              out_valid,
	input wire logic                              out_ready,
	input wire logic                              hit,
	input wire logic signed [lfu_pkg::DATA_W-1:0] read_value
);

	// a stalled result holds
	`LFU_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(hit) && $stable(read_value))

	// a miss always reads as minus one
	`LFU_ASSERT_NOW(a_miss_value, clk, arst_n, out_valid && !hit, read_value == lfu_pkg::MISS_VALUE)

	// the block is busy right after taking an item
	`LFU_ASSERT_NEXT(a_busy_after_accept, clk, arst_n, in_valid && in_ready, !in_ready)

	// no result appears the cycle after an item is taken
	`LFU_ASSERT_NEXT(a_no_early_result, clk, arst_n, in_valid && in_ready, !$rose(out_valid))

endmodule

bind lfu_cache lfu_chk u_lfu_chk (.*);

`default_nettype wire
